[rtl/pwa_pkg.sv]
// Package for the plane wave accumulate block: widths, phase constants,
// item structs, the CORDIC arctangent table and saturation helper.
// No dependencies; used by every RTL file of the block but pwa_checker.
package pwa_pkg;

   // Number of space dimensions the block works in by default.
   localparam int DIMENSIONS_DEFAULT = 3;

   // Configuration register indexes.
   localparam int NUM_REGS    = 8;
   localparam int REG_ADDR_W  = 5;
   localparam logic [2:0] REG_WAVE_X     = 3'd0;
   localparam logic [2:0] REG_WAVE_Y     = 3'd1;
   localparam logic [2:0] REG_WAVE_Z     = 3'd2;
   localparam logic [2:0] REG_CENTER_X   = 3'd3;
   localparam logic [2:0] REG_CENTER_Y   = 3'd4;
   localparam logic [2:0] REG_CENTER_Z   = 3'd5;
   localparam logic [2:0] REG_ANG_FREQ   = 3'd6;
   localparam logic [2:0] REG_TIME_NOW   = 3'd7;

   // Phase constants in Q16.16.
   localparam int TWO_PI_Q  = 411775;
   localparam int PI_Q      = 205887;
   localparam int HALF_PI_Q = 102944;

   // Phase word and its magnitude; the sum of products stays below 2^50.
   localparam int PH_W      = 51;
   localparam int MAG_W     = 50;
   localparam int MOD_STEPS = 32;

   // CORDIC datapath.
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

   // Fields that ride along with an item through the pipeline.
   typedef struct packed {
      logic               last;
      logic signed [31:0] amp;
      logic signed [31:0] sol;
      logic signed [31:0] gx;
      logic signed [31:0] gy;
      logic signed [31:0] gz;
   } side_type;

   // Item inside the phase reduction chain.
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
      side_type         side;
   } mod_item_type;

   // Item inside the CORDIC chain.
   typedef struct packed {
      logic                       flip;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      side_type                   side;
   } cordic_item_type;

   // Arctangent of 2^-i in Q2.30, truncated; the last three entries are rounded.
   function automatic logic [31:0] cordic_atan(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'd843314856;
         5'd1:  v = 32'd497837829;
         5'd2:  v = 32'd263043836;
         5'd3:  v = 32'd133525158;
         5'd4:  v = 32'd67021686;
         5'd5:  v = 32'd33543515;
         5'd6:  v = 32'd16775850;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194282;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048575;
         5'd11: v = 32'd524287;
         5'd12: v = 32'd262143;
         5'd13: v = 32'd131071;
         5'd14: v = 32'd65535;
         5'd15: v = 32'd32767;
         5'd16: v = 32'd16383;
         5'd17: v = 32'd8191;
         5'd18: v = 32'd4095;
         5'd19: v = 32'd2047;
         5'd20: v = 32'd1023;
         5'd21: v = 32'd511;
         5'd22: v = 32'd255;
         5'd23: v = 32'd127;
         5'd24: v = 32'd63;
         5'd25: v = 32'd31;
         5'd26: v = 32'd15;
         5'd27: v = 32'd8;
         5'd28: v = 32'd4;
         5'd29: v = 32'd2;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // Clamp a 53-bit signed sum to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
      logic signed [31:0] r;
      if (v > 53'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -53'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/plane_wave_accumulate_core.sv]
// Throughput: one item per cycle; the pipeline of 32 reduction cells and
// 30 CORDIC cells moves as one and stalls only while a result waits.
// Reset clears the configuration registers and all valid bits; no
// clearing pass is needed and items are taken on the first cycle after.
// Top level of the plane wave accumulate block; depends on pwa_pkg,
// pwa_mod_cell and pwa_cordic_cell.
module plane_wave_accumulate_core
   import pwa_pkg::*;
#(
   parameter int DIMENSIONS = DIMENSIONS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // pos_x, pos_y, pos_z, amplitude, sol_in, grad_x_in, grad_y_in, grad_z_in
   input  logic [255:0]          req_tdata,
   input  logic                  req_tlast,   // last_item
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sol_out, grad_x_out, grad_y_out, grad_z_out
   output logic [127:0]          rsp_tdata,
   output logic                  rsp_tlast,   // last_out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [REG_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic signed [31:0] regs_ff [NUM_REGS];
   logic               advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         regs_ff[csr_paddr[4:2]] <= csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = regs_ff[csr_paddr[4:2]];

   logic signed [31:0] kx, ky, kz;
   assign kx = regs_ff[REG_WAVE_X];
   assign ky = regs_ff[REG_WAVE_Y];
   assign kz = regs_ff[REG_WAVE_Z];

   // The whole pipeline moves whenever the output register can take a result.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Stage 0: register the item and form the offsets from the center.
   logic                s0_valid_ff;
   side_type            s0_side_ff, s0_side_in;
   logic signed [32:0]  dx_ff, dy_ff, dz_ff;

   always_comb begin
      s0_side_in.last = req_tlast;
      s0_side_in.amp  = req_tdata[127:96];
      s0_side_in.sol  = req_tdata[159:128];
      s0_side_in.gx   = req_tdata[191:160];
      s0_side_in.gy   = req_tdata[223:192];
      s0_side_in.gz   = req_tdata[255:224];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_side_ff <= s0_side_in;
         dx_ff <= 33'($signed(req_tdata[31:0])) - 33'(regs_ff[REG_CENTER_X]);
         dy_ff <= 33'($signed(req_tdata[63:32])) - 33'(regs_ff[REG_CENTER_Y]);
         dz_ff <= 33'($signed(req_tdata[95:64])) - 33'(regs_ff[REG_CENTER_Z]);
      end
   end

   // Stage 1: the four phase products.
   logic               s1_valid_ff;
   side_type           s1_side_ff;
   logic signed [64:0] px_ff, py_ff, pz_ff;
   logic signed [63:0] wt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff <= s0_side_ff;
         px_ff <= 65'(kx) * 65'(dx_ff);
         py_ff <= 65'(ky) * 65'(dy_ff);
         pz_ff <= 65'(kz) * 65'(dz_ff);
         wt_ff <= 64'(regs_ff[REG_ANG_FREQ]) * 64'(regs_ff[REG_TIME_NOW]);
      end
   end

   // Stage 2: phase sum of floor-shifted products.
   logic                  s2_valid_ff;
   side_type              s2_side_ff;
   logic signed [PH_W-1:0] ph_ff;
   logic signed [PH_W-1:0] pz_term;

   assign pz_term = (DIMENSIONS == 3) ? PH_W'(pz_ff >>> 16) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_side_ff <= s1_side_ff;
         ph_ff <= PH_W'(px_ff >>> 16) + PH_W'(py_ff >>> 16) + pz_term
                  - PH_W'(wt_ff >>> 16);
      end
   end

   // Stage 3: split the phase into sign and magnitude for the reduction.
   logic         s3_valid_ff;
   mod_item_type s3_item_ff, s3_item_in;

   always_comb begin
      s3_item_in.neg  = ph_ff[PH_W-1];
      s3_item_in.mag  = ph_ff[PH_W-1] ? MAG_W'(-ph_ff) : MAG_W'(ph_ff);
      s3_item_in.side = s2_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_item_ff <= s3_item_in;
      end
   end

   // Reduction chain: magnitude modulo 2*pi, one shifted subtract per cell.
   logic         mod_valid [MOD_STEPS+1];
   mod_item_type mod_item  [MOD_STEPS+1];

   assign mod_valid[0] = s3_valid_ff;
   assign mod_item[0]  = s3_item_ff;

   for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
      pwa_mod_cell #(
         .SHIFT(MOD_STEPS - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (mod_valid[i]),
         .in_item   (mod_item[i]),
         .out_valid (mod_valid[i+1]),
         .out_item  (mod_item[i+1])
      );
   end

   // Fold stage: floor modulo, map into [-pi, pi], then into the CORDIC range.
   logic            fold_valid_ff;
   cordic_item_type fold_item_ff, fold_item_in;
   logic [18:0]        r0;
   logic signed [20:0] r1, ang;
   logic               flip;

   always_comb begin
      r0 = 19'(mod_item[MOD_STEPS].mag);
      if (mod_item[MOD_STEPS].neg && (r0 != '0)) begin
         r1 = 21'(TWO_PI_Q) - 21'($signed({2'b0, r0}));
      end else begin
         r1 = 21'($signed({2'b0, r0}));
      end
      if (r1 > 21'(PI_Q)) begin
         r1 = r1 - 21'(TWO_PI_Q);
      end
      flip = 1'b0;
      ang  = r1;
      if (r1 > 21'(HALF_PI_Q)) begin
         ang  = r1 - 21'(PI_Q);
         flip = 1'b1;
      end else if (r1 < -21'(HALF_PI_Q)) begin
         ang  = r1 + 21'(PI_Q);
         flip = 1'b1;
      end
      fold_item_in.flip = flip;
      fold_item_in.x    = CORDIC_START;
      fold_item_in.y    = '0;
      fold_item_in.z    = CORDIC_W'(ang) <<< 14;
      fold_item_in.side = mod_item[MOD_STEPS].side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= mod_valid[MOD_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_item_ff <= fold_item_in;
      end
   end

   // CORDIC chain, one rotation per cell.
   logic            cor_valid [CORDIC_STEPS+1];
   cordic_item_type cor_item  [CORDIC_STEPS+1];

   assign cor_valid[0] = fold_valid_ff;
   assign cor_item[0]  = fold_item_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      pwa_cordic_cell #(
         .STEP(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cor_valid[i]),
         .in_item   (cor_item[i]),
         .out_valid (cor_valid[i+1]),
         .out_item  (cor_item[i+1])
      );
   end

   // Post stage 1: scale to Q16.16 and undo the half-turn fold.
   logic               p1_valid_ff;
   side_type           p1_side_ff;
   logic signed [19:0] cos_ff, nsin_ff;
   logic signed [19:0] cos_raw, sin_raw;

   assign cos_raw = 20'(cor_item[CORDIC_STEPS].x >>> 14);
   assign sin_raw = 20'(cor_item[CORDIC_STEPS].y >>> 14);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= cor_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_side_ff <= cor_item[CORDIC_STEPS].side;
         cos_ff  <= cor_item[CORDIC_STEPS].flip ? -cos_raw : cos_raw;
         nsin_ff <= cor_item[CORDIC_STEPS].flip ? sin_raw : -sin_raw;
      end
   end

   // Post stage 2: k times minus sine, and amplitude times cosine.
   logic               p2_valid_ff;
   side_type           p2_side_ff;
   logic signed [35:0] tx_ff, ty_ff, tz_ff;
   logic signed [51:0] cprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_side_ff <= p1_side_ff;
         tx_ff <= 36'((52'(kx) * 52'(nsin_ff)) >>> 16);
         ty_ff <= 36'((52'(ky) * 52'(nsin_ff)) >>> 16);
         tz_ff <= 36'((52'(kz) * 52'(nsin_ff)) >>> 16);
         cprod_ff <= 52'(p1_side_ff.amp) * 52'(cos_ff);
      end
   end

   // Post stage 3: amplitude times the gradient terms, and the cosine product, all floor-shifted.
   logic               p3_valid_ff;
   side_type           p3_side_ff;
   logic signed [51:0] gxt_ff, gyt_ff, gzt_ff;
   logic signed [35:0] ct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_side_ff <= p2_side_ff;
         gxt_ff <= 52'((68'(p2_side_ff.amp) * 68'(tx_ff)) >>> 16);
         gyt_ff <= 52'((68'(p2_side_ff.amp) * 68'(ty_ff)) >>> 16);
         gzt_ff <= 52'((68'(p2_side_ff.amp) * 68'(tz_ff)) >>> 16);
         ct_ff  <= 36'(cprod_ff >>> 16);
      end
   end

   // Output register: saturated sums.
   logic               out_valid_ff;
   logic               out_last_ff;
   logic signed [31:0] sol_ff, gx_ff, gy_ff, gz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_last_ff <= p3_side_ff.last;
         sol_ff <= sat32(53'(p3_side_ff.sol) + 53'(ct_ff));
         gx_ff  <= sat32(53'(p3_side_ff.gx) + 53'(gxt_ff));
         gy_ff  <= sat32(53'(p3_side_ff.gy) + 53'(gyt_ff));
         gz_ff  <= (DIMENSIONS == 3) ? sat32(53'(p3_side_ff.gz) + 53'(gzt_ff)) : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {gz_ff, gy_ff, gx_ff, sol_ff};

endmodule

[rtl/pwa_mod_cell.sv]
// One cell of the phase reduction chain: a conditional subtract of
// 2*pi shifted left by a fixed amount. Depends on pwa_pkg.
module pwa_mod_cell
   import pwa_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  mod_item_type in_item,
   output logic         out_valid,
   output mod_item_type out_item
);

   localparam logic [MAG_W-1:0] SUB = MAG_W'(TWO_PI_Q) << SHIFT;

   logic         valid_ff;
   mod_item_type item_ff, item_in;

   // Take off the shifted modulus when it fits.
   always_comb begin
      item_in = in_item;
      if (in_item.mag >= SUB) begin
         item_in.mag = in_item.mag - SUB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[rtl/pwa_cordic_cell.sv]
// One rotation cell of the CORDIC chain, fixed to one iteration index.
// Depends on pwa_pkg for the arctangent table and item struct.
module pwa_cordic_cell
   import pwa_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  cordic_item_type in_item,
   output logic            out_valid,
   output cordic_item_type out_item
);

   localparam logic signed [CORDIC_W-1:0] ATAN = CORDIC_W'(cordic_atan(5'(STEP)));

   logic            valid_ff;
   cordic_item_type item_ff, item_in;

   // Rotate toward a zero residual angle; zero counts as positive.
   always_comb begin
      item_in = in_item;
      if (!in_item.z[CORDIC_W-1]) begin
         item_in.x = in_item.x - (in_item.y >>> STEP);
         item_in.y = in_item.y + (in_item.x >>> STEP);
         item_in.z = in_item.z - ATAN;
      end else begin
         item_in.x = in_item.x + (in_item.y >>> STEP);
         item_in.y = in_item.y - (in_item.x >>> STEP);
         item_in.z = in_item.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[rtl/pwa_checker.sv]
// Port-level checker for the plane wave accumulate core, bound to the top.
// Depends only on the top level's ports.
module pwa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // A waiting result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");

   // A stalled output stalls the input side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while pipeline stalled");

   // With the output empty the block always takes an item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

endmodule

bind plane_wave_accumulate_core pwa_checker u_pwa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

[test/plane_wave_checker.sv]
// Checker for the plane wave accumulate block: watches the req and rsp
// channels and the register port, predicts each result and compares it.
// Depends on pwa_pkg for the register indexes and phase constants.
module plane_wave_checker
   import pwa_pkg::*;
#(
   parameter int DIMENSIONS = DIMENSIONS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [255:0]          req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [127:0]          rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [REG_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] sol;
      logic [31:0] gx;
      logic [31:0] gy;
      logic [31:0] gz;
      logic        last;
   } wave_sum_type;

   localparam longint ATAN_Q30 [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
      15, 8, 4, 2};

   longint       wave_regs [NUM_REGS];
   wave_sum_type expected_sums [$];

   assign pending = expected_sums.size();

   // Arithmetic shift right is a floor shift on signed longint.
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic wave_sum_type predict_wave_sum(logic [255:0] d, logic last);
      longint px, py, pz, amp, sol, gx, gy, gz, ph, r, x, y, z, nx, c, s, ns;
      bit flip;
      wave_sum_type res;
      px  = longint'($signed(d[31:0]));
      py  = longint'($signed(d[63:32]));
      pz  = longint'($signed(d[95:64]));
      amp = longint'($signed(d[127:96]));
      sol = longint'($signed(d[159:128]));
      gx  = longint'($signed(d[191:160]));
      gy  = longint'($signed(d[223:192]));
      gz  = longint'($signed(d[255:224]));
      ph = floor_shr(wave_regs[REG_WAVE_X] * (px - wave_regs[REG_CENTER_X]), 16)
         + floor_shr(wave_regs[REG_WAVE_Y] * (py - wave_regs[REG_CENTER_Y]), 16);
      if (DIMENSIONS == 3)
         ph += floor_shr(wave_regs[REG_WAVE_Z] * (pz - wave_regs[REG_CENTER_Z]), 16);
      ph -= floor_shr(wave_regs[REG_ANG_FREQ] * wave_regs[REG_TIME_NOW], 16);
      // Reduce into (-pi, pi], then fold into the CORDIC range.
      r = ph % TWO_PI_Q;
      if (r < 0) r += TWO_PI_Q;
      if (r > PI_Q) r -= TWO_PI_Q;
      flip = 0;
      if (r > HALF_PI_Q) begin
         r -= PI_Q;
         flip = 1;
      end else if (r < -HALF_PI_Q) begin
         r += PI_Q;
         flip = 1;
      end
      x = CORDIC_START;
      y = 0;
      z = r * 16384;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - floor_shr(y, i);
            y  = y + floor_shr(x, i);
            z -= ATAN_Q30[i];
         end else begin
            nx = x + floor_shr(y, i);
            y  = y - floor_shr(x, i);
            z += ATAN_Q30[i];
         end
         x = nx;
      end
      c = floor_shr(x, 14);
      s = floor_shr(y, 14);
      if (flip) begin
         c = -c;
         s = -s;
      end
      ns = -s;
      res.sol = 32'(clamp32(sol + floor_shr(amp * c, 16)));
      res.gx = 32'(clamp32(gx + floor_shr(amp *
               floor_shr(wave_regs[REG_WAVE_X] * ns, 16), 16)));
      res.gy = 32'(clamp32(gy + floor_shr(amp *
               floor_shr(wave_regs[REG_WAVE_Y] * ns, 16), 16)));
      if (DIMENSIONS == 3)
         res.gz = 32'(clamp32(gz + floor_shr(amp *
                  floor_shr(wave_regs[REG_WAVE_Z] * ns, 16), 16)));
      else
         res.gz = '0;
      res.last = last;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   // Track register writes, predict accepted items and check results.
   always @(posedge clock) begin
      wave_sum_type want;
      if (reset) begin
         foreach (wave_regs[i]) wave_regs[i] = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               $display("unexpected result item at %0t", $realtime);
               fail_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_tdata[31:0] !== want.sol)
                  report_mismatch("sol_out", rsp_tdata[31:0], want.sol);
               if (rsp_tdata[63:32] !== want.gx)
                  report_mismatch("grad_x_out", rsp_tdata[63:32], want.gx);
               if (rsp_tdata[95:64] !== want.gy)
                  report_mismatch("grad_y_out", rsp_tdata[95:64], want.gy);
               if (rsp_tdata[127:96] !== want.gz)
                  report_mismatch("grad_z_out", rsp_tdata[127:96], want.gz);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_out", 32'(rsp_tlast), 32'(want.last));
            end
         end
         if (req_tvalid && req_tready)
            expected_sums.push_back(predict_wave_sum(req_tdata, req_tlast));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[1:0] == 2'b00 && csr_paddr[REG_ADDR_W-1:2] < NUM_REGS)
            wave_regs[csr_paddr[REG_ADDR_W-1:2]] =
               longint'($signed(csr_pwdata));
      end
   end

endmodule

[test/testbench.sv]
// Top of the plane wave accumulate testbench: clock, reset, register writes,
// item stimulus with idling phases, watchdog and verdict.
// Depends on pwa_pkg, plane_wave_accumulate_core and plane_wave_checker.
module testbench;
   import pwa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 90;

   logic                  clock = 0;
   logic                  reset = 1;
   logic [255:0]          req_tdata = '0;
   logic                  req_tlast = 0;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [127:0]          rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic                  csr_psel = 0;
   logic                  csr_penable = 0;
   logic                  csr_pwrite = 0;
   logic [REG_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 0;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   plane_wave_accumulate_core u_dut (.*);

   plane_wave_checker u_checker (.*);

   // Watchdog: count cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when asked.
   always @(negedge clock) begin
      if (reset || hold_off)
         rsp_tready <= 0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= REG_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // Offer one item and hold it until taken; gaps before it at random.
   // The valid stays high after the accept so that items can follow back to
   // back; an idle gap or a drain drops it.
   task automatic send_item(logic [255:0] d, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tdata <= d;
      req_tlast <= last;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [255:0] rand_item();
      logic [255:0] d;
      for (int i = 0; i < 8; i++) d[32*i +: 32] = rand_field();
      return d;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_wave(logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] w, logic [31:0] t);
      write_reg(REG_WAVE_X, kx);
      write_reg(REG_WAVE_Y, ky);
      write_reg(REG_WAVE_Z, kz);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_CENTER_Z, cz);
      write_reg(REG_ANG_FREQ, w);
      write_reg(REG_TIME_NOW, t);
   endtask

   initial begin
      logic [255:0] d;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part: extremes of every field at a moderate wave, including
      // saturation of every sum.
      set_wave(32'h0001_0000, 32'hFFFF_8000, 32'h0002_0000, 0, 0, 0,
               32'h0000_4000, 32'h0003_0000);
      send_item('0, 0);
      send_item({8{32'h7FFFFFFF}}, 1);
      send_item({8{32'h80000000}}, 0);
      send_item({8{32'hFFFFFFFF}}, 1);
      for (int i = 0; i < 16; i++) begin
         d = '0;
         d[127:96] = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
         d[159:128] = (i % 4 < 2) ? 32'h7FFF0000 : 32'h8000FFFF;
         d[191:160] = d[159:128];
         d[223:192] = d[159:128];
         d[255:224] = d[159:128];
         d[31:0] = 32'(i * 25000);
         d[63:32] = 32'(-i * 17000);
         d[95:64] = 32'(i * 9000);
         send_item(d, i[0]);
      end
      wait_drained();

      // Random part: eight register settings, most with idling or stalls.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_wave(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
            1: set_wave(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
            2: set_wave(0, 0, 0, 0, 0, 0, 0, 0);
            default: set_wave(rand_field(), rand_field(), rand_field(), rand_field(),
                              rand_field(), rand_field(), rand_field(), rand_field());
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         if (phase == 4) begin
            // Long receiver hold-off so the pipeline fills and stalls input.
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(negedge clock);
                  hold_off = 0;
               end
            join_none
         end
         for (int n = 0; n < 80; n++) send_item(rand_item(), $urandom_range(1));
         if (phase == 5) begin
            // Sender pauses until every expected result is back.
            req_tvalid <= 0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
            for (int n = 0; n < 10; n++) send_item(rand_item(), $urandom_range(1));
         end
         wait_drained();
      end

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/pwa_pkg.sv
rtl/pwa_mod_cell.sv
rtl/pwa_cordic_cell.sv
rtl/plane_wave_accumulate_core.sv
rtl/pwa_checker.sv
test/plane_wave_checker.sv
test/testbench.sv
